// ===== rtl/core/qpar_pkg.sv =====
// shared types and constants for the quaternion pair angular rate block
`default_nettype none
package qpar_pkg;
    localparam int QW = 32;
    localparam int RW = 48;
    localparam int Q_FRAC = 30;
    localparam int RATE_SHIFT = 15;
    localparam logic [31:0] SAMPLE_RATE_RESET = 32'd6553600;
    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [47:0] OUT_MAX = 48'h7fff_ffff_ffff;
    localparam logic [47:0] OUT_MIN = 48'h8000_0000_0000;
    // byte address of the sample rate register
    localparam logic [1:0] ADDR_SAMPLE_RATE = 2'd0;

    // operand of a partial product: 33 bits so a negated minimum stays exact
    typedef logic signed [32:0] t_opnd;
    // truncated partial product, Q.30
    typedef logic signed [35:0] t_part;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_quat;

    typedef struct packed {
        t_opnd w;
        t_opnd x;
        t_opnd y;
        t_opnd z;
    } t_quat_ext;
endpackage
`default_nettype wire

// ===== rtl/core/qpar_qmul.sv =====
// two-stage hamilton product: registered partial products, then sum and saturate
`default_nettype none
module qpar_qmul (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  qpar_pkg::t_quat_ext  i_p,
    input  qpar_pkg::t_quat_ext  i_q,
    input  qpar_pkg::t_quat      i_pass,
    output logic                 o_valid,
    output qpar_pkg::t_quat      o_r,
    output qpar_pkg::t_quat      o_pass
);
    qpar_pkg::t_part r_pp [16];
    qpar_pkg::t_part n_pp [16];
    qpar_pkg::t_quat r_pass1;
    qpar_pkg::t_quat r_pass2;
    qpar_pkg::t_quat r_res;
    qpar_pkg::t_quat n_res;
    logic            r_v1;
    logic            r_v2;

    function automatic qpar_pkg::t_part mulq(input qpar_pkg::t_opnd a,
                                             input qpar_pkg::t_opnd b);
        logic signed [65:0] prod;
        prod = a * b;
        return qpar_pkg::t_part'(prod >>> qpar_pkg::Q_FRAC);
    endfunction

    function automatic logic [31:0] satq(input logic signed [37:0] v);
        if (v > $signed({6'd0, qpar_pkg::Q_MAX})) return qpar_pkg::Q_MAX;
        if (v < $signed({6'h3f, qpar_pkg::Q_MIN})) return qpar_pkg::Q_MIN;
        return v[31:0];
    endfunction

    always_comb begin
        n_pp[0]  = mulq(i_p.w, i_q.w);
        n_pp[1]  = mulq(i_p.x, i_q.x);
        n_pp[2]  = mulq(i_p.y, i_q.y);
        n_pp[3]  = mulq(i_p.z, i_q.z);
        n_pp[4]  = mulq(i_p.w, i_q.x);
        n_pp[5]  = mulq(i_p.x, i_q.w);
        n_pp[6]  = mulq(i_p.y, i_q.z);
        n_pp[7]  = mulq(i_p.z, i_q.y);
        n_pp[8]  = mulq(i_p.w, i_q.y);
        n_pp[9]  = mulq(i_p.x, i_q.z);
        n_pp[10] = mulq(i_p.y, i_q.w);
        n_pp[11] = mulq(i_p.z, i_q.x);
        n_pp[12] = mulq(i_p.w, i_q.z);
        n_pp[13] = mulq(i_p.x, i_q.y);
        n_pp[14] = mulq(i_p.y, i_q.x);
        n_pp[15] = mulq(i_p.z, i_q.w);
    end

    always_comb begin
        n_res.w = satq(38'(r_pp[0]) - 38'(r_pp[1]) - 38'(r_pp[2]) - 38'(r_pp[3]));
        n_res.x = satq(38'(r_pp[4]) + 38'(r_pp[5]) + 38'(r_pp[6]) - 38'(r_pp[7]));
        n_res.y = satq(38'(r_pp[8]) - 38'(r_pp[9]) + 38'(r_pp[10]) + 38'(r_pp[11]));
        n_res.z = satq(38'(r_pp[12]) + 38'(r_pp[13]) - 38'(r_pp[14]) + 38'(r_pp[15]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_pp    <= n_pp;
            r_pass1 <= i_pass;
            r_res   <= n_res;
            r_pass2 <= r_pass1;
        end
    end

    assign o_valid = r_v2;
    assign o_r     = r_res;
    assign o_pass  = r_pass2;
endmodule
`default_nettype wire

// ===== rtl/core/qpar_scale.sv =====
// two-stage rate scaling of the vector part with output saturation
`default_nettype none
module qpar_scale (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  qpar_pkg::t_quat     i_e,
    input  wire  [31:0]         i_sample_rate,
    output logic                o_valid,
    output logic [47:0]         o_rate_x,
    output logic [47:0]         o_rate_y,
    output logic [47:0]         o_rate_z,
    output logic                o_clipped
);
    logic signed [64:0] r_prod [3];
    logic signed [64:0] n_prod [3];
    logic [47:0]        r_rate [3];
    logic [47:0]        n_rate [3];
    logic [2:0]         n_clip;
    logic               r_clip;
    logic               r_v1;
    logic               r_v2;
    logic signed [49:0] sh;

    always_comb begin
        n_prod[0] = i_e.x * $signed({1'b0, i_sample_rate});
        n_prod[1] = i_e.y * $signed({1'b0, i_sample_rate});
        n_prod[2] = i_e.z * $signed({1'b0, i_sample_rate});
        sh = '0;
        for (int k = 0; k < 3; k++) begin
            sh = 50'(r_prod[k] >>> qpar_pkg::RATE_SHIFT);
            n_clip[k] = 1'b0;
            if (sh > $signed({2'b00, qpar_pkg::OUT_MAX})) begin
                n_rate[k] = qpar_pkg::OUT_MAX;
                n_clip[k] = 1'b1;
            end else if (sh < $signed({2'b11, qpar_pkg::OUT_MIN})) begin
                n_rate[k] = qpar_pkg::OUT_MIN;
                n_clip[k] = 1'b1;
            end else begin
                n_rate[k] = sh[47:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_prod <= n_prod;
            r_rate <= n_rate;
            r_clip <= |n_clip;
        end
    end

    assign o_valid   = r_v2;
    assign o_rate_x  = r_rate[0];
    assign o_rate_y  = r_rate[1];
    assign o_rate_z  = r_rate[2];
    assign o_clipped = r_clip;
endmodule
`default_nettype wire

// ===== rtl/core/quaternion_pair_angular_rate.sv =====
// top level: quaternion pair to angular rate pipeline with apb sample rate register
//
//  channel   | signals                        | direction
//  ----------+--------------------------------+----------
//  request   | i_valid, o_stall, i_prev_*/cur_*| in
//  result    | o_valid, i_stall, o_rate_*, o_clipped | out
//  config    | apb psel/penable/pwrite/paddr  | in
//
// the pipeline is three hamilton products of two stages each, then two
// stages of rate scaling; one request per cycle sustained while not stalled.
// a stall freezes the whole pipeline; o_stall is asserted only while the
// output holds a result that is stalled. reset clears valids and restores
// the 100 hz sample rate.
`default_nettype none
module quaternion_pair_angular_rate (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [1:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  signed [31:0] i_prev_w,
    input  wire  signed [31:0] i_prev_x,
    input  wire  signed [31:0] i_prev_y,
    input  wire  signed [31:0] i_prev_z,
    input  wire  signed [31:0] i_cur_w,
    input  wire  signed [31:0] i_cur_x,
    input  wire  signed [31:0] i_cur_y,
    input  wire  signed [31:0] i_cur_z,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [47:0] o_rate_x,
    output logic signed [47:0] o_rate_y,
    output logic signed [47:0] o_rate_z,
    output logic               o_clipped
);
    logic [31:0] r_sample_rate;
    logic        en;
    qpar_pkg::t_quat prev, cur, d, f, e, cur1, cur2, unused_pass;
    qpar_pkg::t_quat_ext pc, c0, cc1, dx, fx, c2x;
    logic v1, v2, v3;

    function automatic qpar_pkg::t_quat_ext ext(input qpar_pkg::t_quat q, input logic cj);
        qpar_pkg::t_quat_ext r;
        r.w = 33'(q.w);
        r.x = cj ? -33'(q.x) : 33'(q.x);
        r.y = cj ? -33'(q.y) : 33'(q.y);
        r.z = cj ? -33'(q.z) : 33'(q.z);
        return r;
    endfunction

    assign pready = 1'b1;
    assign prdata = (paddr == qpar_pkg::ADDR_SAMPLE_RATE) ? r_sample_rate : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= qpar_pkg::SAMPLE_RATE_RESET;
        end else if (psel && penable && pwrite && paddr == qpar_pkg::ADDR_SAMPLE_RATE) begin
            r_sample_rate <= pwdata;
        end
    end

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign prev = '{w: i_prev_w, x: i_prev_x, y: i_prev_y, z: i_prev_z};
    assign cur  = '{w: i_cur_w, x: i_cur_x, y: i_cur_y, z: i_cur_z};
    assign pc   = ext(prev, 1'b1);
    assign c0   = ext(cur, 1'b0);
    assign dx   = ext(d, 1'b0);
    assign cc1  = ext(cur1, 1'b1);
    assign fx   = ext(f, 1'b0);
    assign c2x  = ext(cur2, 1'b0);

    // d = conj(prev) * cur
    qpar_qmul u_mul_d (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_valid),
        .i_p(pc), .i_q(c0), .i_pass(cur),
        .o_valid(v1), .o_r(d), .o_pass(cur1)
    );
    // f = conj(cur) * d
    qpar_qmul u_mul_f (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v1),
        .i_p(cc1), .i_q(dx), .i_pass(cur1),
        .o_valid(v2), .o_r(f), .o_pass(cur2)
    );
    // e = f * cur
    qpar_qmul u_mul_e (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v2),
        .i_p(fx), .i_q(c2x), .i_pass(cur2),
        .o_valid(v3), .o_r(e), .o_pass(unused_pass)
    );

    qpar_scale u_scale (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v3),
        .i_e(e), .i_sample_rate(r_sample_rate),
        .o_valid(o_valid), .o_rate_x(o_rate_x), .o_rate_y(o_rate_y),
        .o_rate_z(o_rate_z), .o_clipped(o_clipped)
    );
endmodule
`default_nettype wire
